@@ rtl/mse_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIPS subset executor package
// Request and response types, opcode and function codes, fault codes and
// the fixed address constants shared by the executor files.
// ============================================================================
package mse_pkg;

   // Fixed addresses
   localparam logic [31:0] PC_RESET  = 32'h0040_0000;
   localparam logic [31:0] DATA_BASE = 32'h1000_0000;

   // Fault codes
   localparam logic [1:0] FAULT_OK      = 2'd0;
   localparam logic [1:0] FAULT_UNKNOWN = 2'd1;
   localparam logic [1:0] FAULT_ADDR    = 2'd2;

   // Request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EXEC = 1'b1;

   // Primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   // Data memory operation carried into the memory stage
   typedef enum logic [2:0] {
      MEMOP_NONE,
      MEMOP_LW,
      MEMOP_LB,
      MEMOP_SW,
      MEMOP_SB,
      MEMOP_FILL
   } memop_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  word_index;
      logic [31:0] data_word;
      logic [31:0] instruction_word;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic [1:0]  fault;
   } rsp_type;

endpackage

@@ rtl/mse_stream_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIPS subset executor stream channel
// Valid/ready channel carrying one payload; a request moves on a clock edge
// with valid and ready both high.
// ============================================================================
interface mse_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/mips_subset_instruction_executor_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIPS subset instruction executor
// Executes one MIPS instruction or data preload per request and returns the
// next PC, the register write and a fault code.
// ============================================================================
// The block takes one request per clock while the response side does not
// stall, and handles each request in steps: the accept edge reads both
// register operands from two copies of the register file RAM, the execute
// cycle computes the result, branch target and data address and issues
// the data memory read, and the memory cycle finishes loads, merges byte
// stores, writes back and fills the response register. Back-to-back
// dependencies are forwarded, so a request never waits on the one ahead
// of it. The register file reads as zero until written; data memory words
// that were never written by a preload or store read as undefined values.
// Data memory is big-endian, based at 0x10000000.
module mips_subset_instruction_executor_top #(
   parameter int DATA_WORDS = 1024
) (
   input logic           clock,
   input logic           reset,
   mse_stream_if.sink    req_chan,
   mse_stream_if.source  rsp_chan
);
   import mse_pkg::*;

   localparam int IDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   // Handshake and stage control
   logic accept;
   logic s1_adv;
   logic s2_adv;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;

   // Execute stage
   req_type     s1_req_ff;
   logic        s1_rs_ok_ff;
   logic        s1_rt_ok_ff;
   logic [31:0] pc_ff;

   // Register file state and same-edge forward
   logic [31:0] rf_valid_ff;
   logic        rf_fwd_valid_ff, rf_fwd_valid_in;
   logic [4:0]  rf_fwd_index_ff, rf_fwd_index_in;
   logic [31:0] rf_fwd_value_ff, rf_fwd_value_in;
   logic [31:0] rs_q;
   logic [31:0] rt_q;
   logic        rf_we;

   // Memory stage
   memop_type        s2_memop_ff, s2_memop_in;
   logic [IDX_W-1:0] s2_idx_ff, s2_idx_in;
   logic [1:0]       s2_lane_ff, s2_lane_in;
   logic [31:0]      s2_data_ff, s2_data_in;
   logic [31:0]      s2_npc_ff, s2_npc_in;
   logic             s2_wr_ff, s2_wr_in;
   logic [4:0]       s2_wi_ff, s2_wi_in;
   logic [31:0]      s2_wv_ff, s2_wv_in;
   logic [1:0]       s2_fault_ff, s2_fault_in;

   // Data memory and same-edge forward
   logic             dm_fwd_valid_ff, dm_fwd_valid_in;
   logic [31:0]      dm_fwd_value_ff, dm_fwd_value_in;
   logic [31:0]      dm_q;
   logic             dm_re;
   logic             dm_we;
   logic [31:0]      dm_wdata;

   // Response register
   rsp_type rsp_payload_ff, rsp_payload_in;

   // Execute stage decode
   logic [5:0]  op;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [5:0]  fn;
   logic [31:0] imm;
   logic [31:0] simm;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [31:0] pc4;
   logic [31:0] addr;
   logic [31:0] word_off;
   logic [31:0] word_num;
   logic        addr_ok;
   logic        word_aligned;
   logic [31:0] fill_ext;
   logic        fill_ok;

   // Memory stage results
   logic [31:0] mem_word;
   logic [7:0]  mem_byte;
   logic [31:0] s2_value;

   // Handshake
   assign s2_adv = s2_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign s1_adv = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign s2_valid_in  = s1_adv || (s2_valid_ff && !s2_adv);
   assign out_valid_in = s2_adv || (out_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // Register file: two copies give two read ports
   assign rf_we = s2_adv && s2_wr_ff;

   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rs (
      .clock      (clock),
      .write_en   (rf_we),
      .write_addr (s2_wi_ff),
      .write_data (s2_value),
      .read_en    (accept),
      .read_addr  (req_chan.payload.instruction_word[25:21]),
      .read_data  (rs_q)
   );

   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rt (
      .clock      (clock),
      .write_en   (rf_we),
      .write_addr (s2_wi_ff),
      .write_data (s2_value),
      .read_en    (accept),
      .read_addr  (req_chan.payload.instruction_word[20:16]),
      .read_data  (rt_q)
   );

   // Capture the register write landing on the same edge as the operand read
   assign rf_fwd_valid_in = rf_we;
   assign rf_fwd_index_in = s2_wi_ff;
   assign rf_fwd_value_in = s2_value;

   // Decode fields
   assign op   = s1_req_ff.instruction_word[31:26];
   assign rs   = s1_req_ff.instruction_word[25:21];
   assign rt   = s1_req_ff.instruction_word[20:16];
   assign rd   = s1_req_ff.instruction_word[15:11];
   assign sh   = s1_req_ff.instruction_word[10:6];
   assign fn   = s1_req_ff.instruction_word[5:0];
   assign imm  = {16'd0, s1_req_ff.instruction_word[15:0]};
   assign simm = {{16{s1_req_ff.instruction_word[15]}}, s1_req_ff.instruction_word[15:0]};

   // Operands: memory stage write wins over the same-edge write, then the RAM
   always_comb begin
      op_a = s1_rs_ok_ff ? rs_q : 32'd0;
      if (rf_fwd_valid_ff && (rf_fwd_index_ff == rs)) begin
         op_a = rf_fwd_value_ff;
      end
      if (s2_valid_ff && s2_wr_ff && (s2_wi_ff == rs)) begin
         op_a = s2_value;
      end
      op_b = s1_rt_ok_ff ? rt_q : 32'd0;
      if (rf_fwd_valid_ff && (rf_fwd_index_ff == rt)) begin
         op_b = rf_fwd_value_ff;
      end
      if (s2_valid_ff && s2_wr_ff && (s2_wi_ff == rt)) begin
         op_b = s2_value;
      end
   end

   // Address generation and range checks
   assign pc4          = pc_ff + 32'd4;
   assign addr         = op_a + simm;
   assign word_off     = addr - DATA_BASE;
   assign word_num     = {2'b00, word_off[31:2]};
   assign addr_ok      = word_num < 32'(DATA_WORDS);
   assign word_aligned = (addr[1:0] == 2'b00);
   assign fill_ext     = {22'd0, s1_req_ff.word_index};
   assign fill_ok      = fill_ext < 32'(DATA_WORDS);

   // Execute
   always_comb begin
      s2_npc_in   = pc4;
      s2_wr_in    = 1'b0;
      s2_wi_in    = rt;
      s2_wv_in    = 32'd0;
      s2_fault_in = FAULT_OK;
      s2_memop_in = MEMOP_NONE;
      s2_idx_in   = word_num[IDX_W-1:0];
      s2_lane_in  = addr[1:0];
      s2_data_in  = op_b;
      if (s1_req_ff.kind == KIND_LOAD) begin
         s2_npc_in  = pc_ff;
         s2_idx_in  = fill_ext[IDX_W-1:0];
         s2_data_in = s1_req_ff.data_word;
         if (fill_ok) begin
            s2_memop_in = MEMOP_FILL;
         end else begin
            s2_fault_in = FAULT_ADDR;
         end
      end else begin
         case (op)
            OP_SPECIAL: begin
               s2_wr_in = 1'b1;
               s2_wi_in = rd;
               case (fn)
                  FN_ADDU: s2_wv_in = op_a + op_b;
                  FN_SUBU: s2_wv_in = op_a - op_b;
                  FN_AND:  s2_wv_in = op_a & op_b;
                  FN_OR:   s2_wv_in = op_a | op_b;
                  FN_NOR:  s2_wv_in = ~(op_a | op_b);
                  FN_SLTU: s2_wv_in = {31'd0, op_a < op_b};
                  FN_SLL:  s2_wv_in = op_b << sh;
                  FN_SRL:  s2_wv_in = op_b >> sh;
                  FN_JR: begin
                     s2_wr_in  = 1'b0;
                     s2_npc_in = op_a;
                  end
                  default: begin
                     s2_wr_in    = 1'b0;
                     s2_fault_in = FAULT_UNKNOWN;
                  end
               endcase
            end
            OP_J: begin
               s2_npc_in = {pc4[31:28], s1_req_ff.instruction_word[25:0], 2'b00};
            end
            OP_JAL: begin
               s2_npc_in = {pc4[31:28], s1_req_ff.instruction_word[25:0], 2'b00};
               s2_wr_in  = 1'b1;
               s2_wi_in  = 5'd31;
               s2_wv_in  = pc4;
            end
            OP_BEQ: begin
               if (op_a == op_b) begin
                  s2_npc_in = pc4 + {simm[29:0], 2'b00};
               end
            end
            OP_BNE: begin
               if (op_a != op_b) begin
                  s2_npc_in = pc4 + {simm[29:0], 2'b00};
               end
            end
            OP_ADDIU: begin
               s2_wr_in = 1'b1;
               s2_wv_in = op_a + simm;
            end
            OP_SLTIU: begin
               s2_wr_in = 1'b1;
               s2_wv_in = {31'd0, op_a < simm};
            end
            OP_ANDI: begin
               s2_wr_in = 1'b1;
               s2_wv_in = op_a & imm;
            end
            OP_ORI: begin
               s2_wr_in = 1'b1;
               s2_wv_in = op_a | imm;
            end
            OP_LUI: begin
               s2_wr_in = 1'b1;
               s2_wv_in = {imm[15:0], 16'd0};
            end
            OP_LW: begin
               if (addr_ok && word_aligned) begin
                  s2_wr_in    = 1'b1;
                  s2_memop_in = MEMOP_LW;
               end else begin
                  s2_fault_in = FAULT_ADDR;
               end
            end
            OP_LB: begin
               if (addr_ok) begin
                  s2_wr_in    = 1'b1;
                  s2_memop_in = MEMOP_LB;
               end else begin
                  s2_fault_in = FAULT_ADDR;
               end
            end
            OP_SW: begin
               if (addr_ok && word_aligned) begin
                  s2_memop_in = MEMOP_SW;
               end else begin
                  s2_fault_in = FAULT_ADDR;
               end
            end
            OP_SB: begin
               if (addr_ok) begin
                  s2_memop_in = MEMOP_SB;
               end else begin
                  s2_fault_in = FAULT_ADDR;
               end
            end
            default: begin
               s2_fault_in = FAULT_UNKNOWN;
            end
         endcase
      end
      // Drop writes to r0 and report them as no write
      if (!s2_wr_in || (s2_wi_in == 5'd0)) begin
         s2_wr_in = 1'b0;
         s2_wi_in = 5'd0;
         s2_wv_in = 32'd0;
      end
   end

   // Data memory
   assign dm_re = s1_adv &&
                  ((s2_memop_in == MEMOP_LW) || (s2_memop_in == MEMOP_LB) ||
                   (s2_memop_in == MEMOP_SB));
   assign dm_we = s2_adv &&
                  ((s2_memop_ff == MEMOP_SW) || (s2_memop_ff == MEMOP_SB) ||
                   (s2_memop_ff == MEMOP_FILL));

   mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
      .clock      (clock),
      .write_en   (dm_we),
      .write_addr (s2_idx_ff),
      .write_data (dm_wdata),
      .read_en    (dm_re),
      .read_addr  (s2_idx_in),
      .read_data  (dm_q)
   );

   // Capture the store landing on the same edge as the data read
   assign dm_fwd_valid_in = dm_we && (s2_idx_ff == s2_idx_in);
   assign dm_fwd_value_in = dm_wdata;

   // Memory stage: select the loaded word and byte
   assign mem_word = dm_fwd_valid_ff ? dm_fwd_value_ff : dm_q;

   always_comb begin
      case (s2_lane_ff)
         2'd0:    mem_byte = mem_word[31:24];
         2'd1:    mem_byte = mem_word[23:16];
         2'd2:    mem_byte = mem_word[15:8];
         2'd3:    mem_byte = mem_word[7:0];
         default: mem_byte = mem_word[7:0];
      endcase
   end

   always_comb begin
      s2_value = s2_wv_ff;
      if (s2_wr_ff) begin
         case (s2_memop_ff)
            MEMOP_LW: s2_value = mem_word;
            MEMOP_LB: s2_value = {{24{mem_byte[7]}}, mem_byte};
            default:  s2_value = s2_wv_ff;
         endcase
      end
   end

   // Merge store data into the word
   always_comb begin
      dm_wdata = s2_data_ff;
      if (s2_memop_ff == MEMOP_SB) begin
         case (s2_lane_ff)
            2'd0:    dm_wdata = {s2_data_ff[7:0], mem_word[23:0]};
            2'd1:    dm_wdata = {mem_word[31:24], s2_data_ff[7:0], mem_word[15:0]};
            2'd2:    dm_wdata = {mem_word[31:16], s2_data_ff[7:0], mem_word[7:0]};
            2'd3:    dm_wdata = {mem_word[31:8], s2_data_ff[7:0]};
            default: dm_wdata = s2_data_ff;
         endcase
      end
   end

   // Response payload
   always_comb begin
      rsp_payload_in.next_pc     = s2_npc_ff;
      rsp_payload_in.reg_written = s2_wr_ff;
      rsp_payload_in.reg_index   = s2_wi_ff;
      rsp_payload_in.reg_value   = s2_value;
      rsp_payload_in.fault       = s2_fault_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         pc_ff           <= PC_RESET;
         rf_valid_ff     <= 32'd0;
         rf_fwd_valid_ff <= 1'b0;
         dm_fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv && (s1_req_ff.kind == KIND_EXEC)) begin
            pc_ff <= s2_npc_in;
         end
         if (rf_we) begin
            rf_valid_ff[s2_wi_ff] <= 1'b1;
         end
         if (accept) begin
            rf_fwd_valid_ff <= rf_fwd_valid_in;
         end
         if (s1_adv) begin
            dm_fwd_valid_ff <= dm_fwd_valid_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff       <= req_chan.payload;
         s1_rs_ok_ff     <= rf_valid_ff[req_chan.payload.instruction_word[25:21]];
         s1_rt_ok_ff     <= rf_valid_ff[req_chan.payload.instruction_word[20:16]];
         rf_fwd_index_ff <= rf_fwd_index_in;
         rf_fwd_value_ff <= rf_fwd_value_in;
      end
      if (s1_adv) begin
         s2_memop_ff     <= s2_memop_in;
         s2_idx_ff       <= s2_idx_in;
         s2_lane_ff      <= s2_lane_in;
         s2_data_ff      <= s2_data_in;
         s2_npc_ff       <= s2_npc_in;
         s2_wr_ff        <= s2_wr_in;
         s2_wi_ff        <= s2_wi_in;
         s2_wv_ff        <= s2_wv_in;
         s2_fault_ff     <= s2_fault_in;
         dm_fwd_value_ff <= dm_fwd_value_in;
      end
      if (s2_adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

@@ rtl/mse_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIPS subset executor RAM
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         rdata_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = rdata_ff;
endmodule

@@ tb/mse_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIPS subset executor checker
// Watches the request and response channels, keeps its own copy of the PC,
// register file and data memory, predicts the response for every accepted
// request and compares each accepted response with the oldest prediction.
// ============================================================================
module mse_checker
   import mse_pkg::*;
#(
   parameter int DATA_WORDS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count
);

   // Architectural state as the executor should see it
   bit [31:0] arch_pc;
   bit [31:0] gpr [32];
   bit [31:0] data_mem [DATA_WORDS];

   // Predicted responses, oldest first
   rsp_type retire_q [$];
   rsp_type want;

   // Print one line per mismatch and count it
   task automatic log_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_value);
      if (got !== exp_value)
         log_mismatch($sformatf("response %0d %s: got %h, expected %h",
                                checked_count, name, got, exp_value));
   endtask

   // Execute one request against the architectural state and build the
   // response it must produce
   task automatic predict_retire(input req_type item, output rsp_type outcome);
      bit [31:0] link, pc_next, a, b, simm, zimm, addr, offs, wval;
      bit [5:0]  opc, fnc;
      bit [4:0]  rs, rt, rd, sh, wdst;
      bit [7:0]  lane_byte;
      bit        wen, in_mem;
      bit [1:0]  flt;
      int        slot, bsh;
      link    = arch_pc + 32'd4;
      pc_next = link;
      wen     = 1'b0;
      wdst    = 5'd0;
      wval    = 32'd0;
      flt     = FAULT_OK;
      if (item.kind == KIND_LOAD) begin
         // preload: PC holds, memory word written
         pc_next = arch_pc;
         if (int'(item.word_index) < DATA_WORDS)
            data_mem[item.word_index] = item.data_word;
         else
            flt = FAULT_ADDR;
      end else begin
         {opc, rs, rt, rd, sh, fnc} = item.instruction_word;
         zimm   = {16'h0000, item.instruction_word[15:0]};
         simm   = {{16{item.instruction_word[15]}}, item.instruction_word[15:0]};
         a      = gpr[rs];
         b      = gpr[rt];
         addr   = a + simm;
         offs   = addr - DATA_BASE;
         in_mem = (offs >> 2) < DATA_WORDS;
         slot   = in_mem ? int'(offs >> 2) : 0;
         bsh    = 8 * (3 - int'(addr[1:0]));
         case (opc)
            OP_SPECIAL: begin
               wen  = 1'b1;
               wdst = rd;
               case (fnc)
                  FN_ADDU: wval = a + b;
                  FN_SUBU: wval = a - b;
                  FN_AND:  wval = a & b;
                  FN_OR:   wval = a | b;
                  FN_NOR:  wval = ~(a | b);
                  FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
                  FN_SLL:  wval = b << sh;
                  FN_SRL:  wval = b >> sh;
                  FN_JR: begin
                     wen     = 1'b0;
                     pc_next = a;
                  end
                  default: begin
                     wen = 1'b0;
                     flt = FAULT_UNKNOWN;
                  end
               endcase
            end
            OP_J, OP_JAL: begin
               pc_next = {link[31:28], item.instruction_word[25:0], 2'b00};
               if (opc == OP_JAL) begin
                  wen  = 1'b1;
                  wdst = 5'd31;
                  wval = link;
               end
            end
            OP_BEQ: if (a == b) pc_next = link + (simm << 2);
            OP_BNE: if (a != b) pc_next = link + (simm << 2);
            OP_ADDIU: begin
               wen  = 1'b1;
               wdst = rt;
               wval = a + simm;
            end
            OP_SLTIU: begin
               wen  = 1'b1;
               wdst = rt;
               wval = (a < simm) ? 32'd1 : 32'd0;
            end
            OP_ANDI: begin
               wen  = 1'b1;
               wdst = rt;
               wval = a & zimm;
            end
            OP_ORI: begin
               wen  = 1'b1;
               wdst = rt;
               wval = a | zimm;
            end
            OP_LUI: begin
               wen  = 1'b1;
               wdst = rt;
               wval = {item.instruction_word[15:0], 16'h0000};
            end
            OP_LW: begin
               if (!in_mem || addr[1:0] != 2'd0) begin
                  flt = FAULT_ADDR;
               end else begin
                  wen  = 1'b1;
                  wdst = rt;
                  wval = data_mem[slot];
               end
            end
            OP_LB: begin
               if (!in_mem) begin
                  flt = FAULT_ADDR;
               end else begin
                  lane_byte = 8'(data_mem[slot] >> bsh);
                  wen       = 1'b1;
                  wdst      = rt;
                  wval      = {{24{lane_byte[7]}}, lane_byte};
               end
            end
            OP_SW: begin
               if (!in_mem || addr[1:0] != 2'd0)
                  flt = FAULT_ADDR;
               else
                  data_mem[slot] = b;
            end
            OP_SB: begin
               if (!in_mem)
                  flt = FAULT_ADDR;
               else
                  data_mem[slot] = (data_mem[slot] & ~(32'h0000_00FF << bsh)) |
                                   ({24'h0, b[7:0]} << bsh);
            end
            default: flt = FAULT_UNKNOWN;
         endcase
         // drop writes to r0
         if (wen && wdst == 5'd0)
            wen = 1'b0;
         if (wen) begin
            gpr[wdst] = wval;
         end else begin
            wdst = 5'd0;
            wval = 32'd0;
         end
         arch_pc = pc_next;
      end
      outcome.next_pc     = pc_next;
      outcome.reg_written = wen;
      outcome.reg_index   = wdst;
      outcome.reg_value   = wval;
      outcome.fault       = flt;
   endtask

   // Compare retiring responses, then predict newly accepted requests
   always @(posedge clock) begin
      if (reset) begin
         arch_pc = PC_RESET;
         for (int i = 0; i < 32; i++)
            gpr[i] = 32'd0;
         retire_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (retire_q.size() == 0) begin
               log_mismatch($sformatf("response with nothing outstanding: %p",
                                      rsp_payload));
            end else begin
               want = retire_q.pop_front();
               check_field("next_pc", rsp_payload.next_pc, want.next_pc);
               check_field("reg_written", 32'(rsp_payload.reg_written),
                           32'(want.reg_written));
               check_field("reg_index", 32'(rsp_payload.reg_index), 32'(want.reg_index));
               check_field("reg_value", rsp_payload.reg_value, want.reg_value);
               check_field("fault", 32'(rsp_payload.fault), 32'(want.fault));
               checked_count++;
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            predict_retire(req_payload, want);
            retire_q.insert(retire_q.size(), want);
         end
      end
      pending_count = retire_q.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIPS subset executor testbench
// Drives preload and instruction requests into the executor: a directed
// opening over every operation and corner, then random programs built from
// ALU, memory, control-transfer and raw-word sequences under changing
// back-pressure. The checker beside the block predicts and compares.
// ============================================================================
module tb;
   import mse_pkg::*;

   localparam int DATA_WORDS  = 1024;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_POINTS [2] = '{300, 1400};

   // Encodings that the executor does not implement
   localparam logic [5:0] OP_UNUSED = 6'h3f;
   localparam logic [5:0] FN_UNUSED = 6'h3f;

   localparam logic [5:0] ALU_FNS [8] = '{FN_ADDU, FN_SUBU, FN_AND, FN_OR,
                                          FN_NOR, FN_SLTU, FN_SLL, FN_SRL};
   localparam logic [5:0] IMM_OPS [5] = '{OP_ADDIU, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI};
   localparam logic [5:0] MEM_OPS [4] = '{OP_LW, OP_LB, OP_SW, OP_SB};
   localparam logic [5:0] CTRL_OPS [4] = '{OP_BEQ, OP_BNE, OP_J, OP_JAL};

   logic clock = 1'b0;
   logic reset;

   mse_stream_if #(.payload_type(req_type)) req_if ();
   mse_stream_if #(.payload_type(rsp_type)) rsp_if ();

   int fail_count;
   int pending_count;
   int checked_count;

   // Stimulus bookkeeping
   int issued;
   int send_idle_pct;
   int rcv_idle_pct;
   int n_preload, n_alu, n_mem_seq, n_ctrl, n_raw;
   bit mem_written [DATA_WORDS];

   mips_subset_instruction_executor_top #(.DATA_WORDS(DATA_WORDS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   mse_checker #(.DATA_WORDS(DATA_WORDS)) chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: random stalls plus long hold-offs at fixed request counts
   initial begin
      int hold_left;
      int hold_idx;
      hold_left = 0;
      hold_idx  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_idx < 2 && issued >= HOLD_POINTS[hold_idx]) begin
            hold_left = HOLD_CYCLES;
            hold_idx++;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (int'($urandom_range(99)) >= rcv_idle_pct);
         end
      end
   end

   function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   function automatic logic [4:0] rnd_reg();
      return 5'($urandom_range(31));
   endfunction

   // Offer one request, idling first at random, and wait for acceptance
   task automatic send_request(input req_type item);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      issued++;
   endtask

   task automatic send_exec(input logic [31:0] instr);
      req_type item;
      item.kind             = KIND_EXEC;
      item.word_index       = 10'($urandom);
      item.data_word        = 32'($urandom);
      item.instruction_word = instr;
      send_request(item);
   endtask

   task automatic send_preload(input logic [9:0] index, input logic [31:0] value);
      req_type item;
      item.kind             = KIND_LOAD;
      item.word_index       = index;
      item.data_word        = value;
      item.instruction_word = 32'($urandom);
      if (int'(index) < DATA_WORDS)
         mem_written[index] = 1'b1;
      send_request(item);
   endtask

   // Hold the sender until every outstanding response has come back
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Every operation, field extremes and each corner once
   task automatic run_directed();
      send_preload(10'd0, 32'h8081_7F01);
      send_preload(10'(DATA_WORDS - 1), 32'hFFFF_FFFF);
      send_exec(enc_i(OP_LUI, 5'd0, 5'd1, DATA_BASE[31:16]));
      send_exec(enc_i(OP_LW, 5'd1, 5'd2, 16'h0000));
      send_exec(enc_i(OP_LB, 5'd1, 5'd3, 16'h0000));   // sign-extended byte
      send_exec(enc_i(OP_LW, 5'd1, 5'd5, 16'h0FFC));   // last word
      send_exec(enc_i(OP_LW, 5'd1, 5'd6, 16'h0001));   // misaligned word
      send_exec(enc_i(OP_SB, 5'd1, 5'd2, 16'h0FFD));
      mem_written[1] = 1'b1;
      send_exec(enc_i(OP_SW, 5'd1, 5'd3, 16'h0004));
      send_exec(enc_i(OP_LW, 5'd1, 5'd7, 16'h0004));   // load right behind store
      send_exec(enc_r(FN_ADDU, 5'd2, 5'd5, 5'd8, 5'd0));
      send_exec(enc_r(FN_SUBU, 5'd3, 5'd2, 5'd9, 5'd0));
      send_exec(enc_r(FN_NOR, 5'd0, 5'd0, 5'd10, 5'd0));
      send_exec(enc_r(FN_AND, 5'd2, 5'd10, 5'd11, 5'd0));
      send_exec(enc_r(FN_OR, 5'd9, 5'd3, 5'd12, 5'd0));
      send_exec(enc_r(FN_SLTU, 5'd3, 5'd10, 5'd13, 5'd0));
      send_exec(enc_r(FN_SLL, 5'd0, 5'd10, 5'd14, 5'd31));
      send_exec(enc_r(FN_SRL, 5'd0, 5'd10, 5'd15, 5'd31));
      send_exec(enc_i(OP_ADDIU, 5'd0, 5'd16, 16'h8000));
      send_exec(enc_i(OP_SLTIU, 5'd16, 5'd17, 16'hFFFF));
      send_exec(enc_i(OP_ANDI, 5'd10, 5'd18, 16'hFFFF));
      send_exec(enc_i(OP_ORI, 5'd0, 5'd19, 16'h8000));
      send_exec(enc_i(OP_LUI, 5'd0, 5'd20, 16'hFFFF));
      send_exec(enc_i(OP_ADDIU, 5'd10, 5'd0, 16'h0001)); // write to r0 dropped
      send_exec(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
      send_exec(enc_i(OP_BNE, 5'd10, 5'd0, 16'h7FFF));
      send_exec(enc_j(OP_J, 26'h3FF_FFFF));
      send_exec(enc_j(OP_JAL, 26'h000_0000));
      send_exec(enc_r(FN_JR, 5'd16, 5'd0, 5'd0, 5'd0));
      send_exec(enc_i(OP_UNUSED, 5'd0, 5'd0, 16'h0000));
      send_exec(enc_r(FN_UNUSED, 5'd1, 5'd2, 5'd3, 5'd0));
   endtask

   // Register-register or register-immediate operation with random fields
   task automatic run_alu_op();
      logic [5:0]  fn;
      logic [15:0] imm;
      n_alu++;
      if ($urandom_range(1) == 0) begin
         fn = ($urandom_range(9) == 0) ? 6'($urandom) : ALU_FNS[$urandom_range(7)];
         send_exec(enc_r(fn, rnd_reg(), rnd_reg(), rnd_reg(), 5'($urandom)));
      end else begin
         case ($urandom_range(5))
            0:       imm = 16'h0000;
            1:       imm = 16'h7FFF;
            2:       imm = 16'h8000;
            3:       imm = 16'hFFFF;
            default: imm = 16'($urandom);
         endcase
         send_exec(enc_i(IMM_OPS[$urandom_range(4)], rnd_reg(), rnd_reg(), imm));
      end
   endtask

   // Set a base register, optionally nudge it, then issue memory accesses
   // through it; reads only touch words already written
   task automatic run_memory_sequence();
      logic [4:0]  rb, rt;
      logic [5:0]  opc;
      logic [15:0] hi, adj, off;
      logic [31:0] base, tgt, addr, offs;
      int          n_ops, slot, lane;
      bit          in_mem, aligned, reads_data;
      n_mem_seq++;
      rb = 5'($urandom_range(31, 1));
      case ($urandom_range(9))
         0:       hi = DATA_BASE[31:16] - 16'd1;
         1:       hi = DATA_BASE[31:16] + 16'd1;
         2:       hi = 16'($urandom);
         default: hi = DATA_BASE[31:16];
      endcase
      send_exec(enc_i(OP_LUI, rnd_reg(), rb, hi));
      base = {hi, 16'h0000};
      if ($urandom_range(2) == 0) begin
         adj = 16'($urandom_range(4095)) - 16'd2048;
         send_exec(enc_i(OP_ADDIU, rb, rb, adj));
         base = base + {{16{adj[15]}}, adj};
      end
      off   = 16'h0000;
      n_ops = $urandom_range(3, 1);
      for (int k = 0; k < n_ops; k++) begin
         opc = MEM_OPS[$urandom_range(3)];
         // reuse the previous offset now and then, so a store can be followed by a load
         if (k == 0 || $urandom_range(2) != 0) begin
            if ($urandom_range(6) == 0) begin
               off = 16'($urandom);
            end else begin
               case ($urandom_range(4))
                  0:       slot = 0;
                  1:       slot = DATA_WORDS - 1;
                  default: slot = $urandom_range(DATA_WORDS - 1);
               endcase
               if (opc == OP_LW || opc == OP_SW)
                  lane = ($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0;
               else
                  lane = $urandom_range(3);
               tgt = DATA_BASE + 32'(slot) * 32'd4 + 32'(lane);
               off = 16'(tgt - base);
            end
         end
         addr    = base + {{16{off[15]}}, off};
         offs    = addr - DATA_BASE;
         in_mem  = (offs >> 2) < DATA_WORDS;
         aligned = (addr[1:0] == 2'd0);
         slot    = in_mem ? int'(offs >> 2) : 0;
         reads_data = in_mem && (opc == OP_LB || opc == OP_SB || (opc == OP_LW && aligned));
         if (reads_data && !mem_written[slot])
            opc = OP_SW;
         if (opc == OP_SW && in_mem && aligned)
            mem_written[slot] = 1'b1;
         rt = rnd_reg();
         // a load must not clobber the base mid-sequence
         if (rt == rb && (opc == OP_LW || opc == OP_LB))
            rt = 5'd0;
         send_exec(enc_i(opc, rb, rt, off));
      end
   endtask

   // Branches, jumps and register jumps
   task automatic run_control_transfer();
      logic [4:0] rs, rt;
      logic [5:0] opc;
      n_ctrl++;
      if ($urandom_range(4) == 0) begin
         send_exec({OP_SPECIAL, rnd_reg(), 15'($urandom), FN_JR});
      end else begin
         opc = CTRL_OPS[$urandom_range(3)];
         rs  = rnd_reg();
         rt  = ($urandom_range(1) == 0) ? rs : rnd_reg();
         if (opc == OP_J || opc == OP_JAL)
            send_exec(enc_j(opc, 26'($urandom)));
         else
            send_exec(enc_i(opc, rs, rt, 16'($urandom)));
      end
   endtask

   // Arbitrary instruction word; loads and byte stores keep r0 as base so
   // they stay outside the data memory
   task automatic run_raw_word();
      logic [31:0] word;
      n_raw++;
      word = 32'($urandom);
      if (word[31:26] == OP_LW || word[31:26] == OP_LB || word[31:26] == OP_SB)
         word[25:21] = 5'd0;
      send_exec(word);
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int pick;
      stop_at = issued + count;
      while (issued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            n_preload++;
            send_preload(10'($urandom), 32'($urandom));
         end else if (pick < 47) begin
            run_alu_op();
         end else if (pick < 75) begin
            run_memory_sequence();
         end else if (pick < 88) begin
            run_control_transfer();
         end else begin
            run_raw_word();
         end
      end
   endtask

   // Main stimulus and verdict
   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      send_idle_pct  = 0;
      rcv_idle_pct   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain_responses();

      send_idle_pct = 9;
      rcv_idle_pct  = 53;
      run_random(600);
      drain_responses();

      send_idle_pct = 53;
      rcv_idle_pct  = 9;
      run_random(600);
      drain_responses();

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      run_random(620);
      drain_responses();
      repeat (10) @(posedge clock);

      $display("Covered %0d requests: %0d preloads, %0d ALU ops, %0d memory sequences,",
               issued, n_preload, n_alu, n_mem_seq);
      $display("%0d control transfers, %0d raw words; %0d responses compared",
               n_ctrl, n_raw, checked_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", pending_count);
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mse_pkg.sv
rtl/mse_stream_if.sv
rtl/mse_ram.sv
rtl/mips_subset_instruction_executor_top.sv
tb/mse_checker.sv
tb/tb.sv
